### rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Types, status codes and the CRC-8 step shared by the scratchpad frame
// checker.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned FRAME_DATA_BYTES = 8;
  localparam int unsigned COUNT_W          = 4;
  localparam logic [7:0]  CRC_POLY         = 8'h8C;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CRC   = 2'd1;
  localparam logic [1:0] ST_NODEV = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic signed [15:0] SENTINEL_CRC   = 16'sd16000;
  localparam logic signed [15:0] SENTINEL_NODEV = 16'sd17600;
  localparam logic signed [15:0] SENTINEL_ZERO  = 16'sd19200;

  typedef struct packed {
    logic       no_presence;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] reading;
  } result_t;

  // reflected CRC-8, LSB first, one byte per call
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] data;
    logic       feedback;
    crc  = crc_in;
    data = data_in;
    for (int k = 0; k < 8; k++) begin
      feedback = crc[0] ^ data[0];
      crc      = crc >> 1;
      if (feedback) begin
        crc = crc ^ CRC_POLY;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

endpackage

### rtl/sfc_frame.sv
// ----------------------------------------------------------------------------
// sfc_frame
// Frame state (byte count, running CRC, nonzero flag, bytes 0 and 1) and the
// result decision for each accepted word.
// ----------------------------------------------------------------------------
module sfc_frame
  import sfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output logic    res_fire,
  output result_t res
);

  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         running_crc;
  logic               any_nonzero;
  logic [7:0]         reading_low;
  logic [7:0]         reading_high;

  logic data_byte;

  assign data_byte = (byte_count < COUNT_W'(FRAME_DATA_BYTES));

  always_comb begin
    res_fire = fire && (item.no_presence || !data_byte);
    if (item.no_presence) begin
      res.status  = ST_NODEV;
      res.reading = SENTINEL_NODEV;
    end else if (!any_nonzero) begin
      res.status  = ST_ZERO;
      res.reading = SENTINEL_ZERO;
    end else if (running_crc != item.rx_byte) begin
      res.status  = ST_CRC;
      res.reading = SENTINEL_CRC;
    end else begin
      res.status  = ST_OK;
      res.reading = {reading_high, reading_low};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_crc  <= '0;
      any_nonzero  <= 1'b0;
      reading_low  <= '0;
      reading_high <= '0;
    end else if (fire) begin
      if (item.no_presence || !data_byte) begin
        byte_count   <= '0;
        running_crc  <= '0;
        any_nonzero  <= 1'b0;
        reading_low  <= '0;
        reading_high <= '0;
      end else begin
        running_crc <= crc8_byte(running_crc, item.rx_byte);
        if (item.rx_byte != 8'h00) begin
          any_nonzero <= 1'b1;
        end
        if (byte_count == COUNT_W'(0)) begin
          reading_low <= item.rx_byte;
        end else if (byte_count == COUNT_W'(1)) begin
          reading_high <= item.rx_byte;
        end
        byte_count <= byte_count + COUNT_W'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(FRAME_DATA_BYTES))
    else $error("byte count past frame length");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> (byte_count == '0 && running_crc == '0 && !any_nonzero))
    else $error("frame state not cleared after result");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (byte_count == '0) |-> !any_nonzero)
    else $error("nonzero flag set with empty frame");

endmodule

### rtl/sensor_scratchpad_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// sensor_scratchpad_frame_checker_unit
// Checks the nine-byte scratchpad frame of a single-wire temperature sensor
// and reports status and reading once per frame or failed bus reset.
//
//   channel  direction  handshake                 word
//   item     in         item_valid / item_stall   item_t   (no_presence, rx_byte)
//   result   out        result_valid / result_stall result_t (status, reading)
//
// One word is accepted every cycle while item_stall is low; a result is
// registered from the word that causes it (ninth byte or failed bus reset).
// The CRC over one byte is a single unrolled step between the frame
// registers, so only item_stall limits the rate below one word per cycle.
// Synchronous active-high reset clears the frame state and both result slots.
// A stalled result holds in the output register; one more result lands in a
// skid slot, and only while that slot is full is item_stall raised.
// ----------------------------------------------------------------------------
module sensor_scratchpad_frame_checker_unit
  import sfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    fire;
  logic    res_fire;
  result_t res;
  logic    take;
  logic    skid_valid;
  result_t skid;

  assign item_stall = skid_valid;
  assign fire       = item_valid && !item_stall;
  assign take       = result_valid && !result_stall;

  sfc_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (item),
    .res_fire (res_fire),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || take) begin
      if (skid_valid) begin
        result <= skid;
      end else if (res_fire) begin
        result <= res;
      end
    end else if (res_fire) begin
      skid <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid slot full with output empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !result_stall) |=> (result_valid && !skid_valid))
    else $error("skid slot did not move to output");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (res_fire && result_valid && result_stall) |=> skid_valid)
    else $error("result dropped while output stalled");

endmodule

### verif/tb_sensor_scratchpad_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_sensor_scratchpad_frame_checker_unit
// Drives scratchpad frames, failed bus resets and broken frames into the
// checker, predicts status and reading for each word, and compares every
// result against the oldest prediction under random idling and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sensor_scratchpad_frame_checker_unit
  import sfc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET    = 1900;
  localparam int unsigned IDLE_PCT       = 7;
  localparam int unsigned HOLD_CYCLES    = 90;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 4;

  typedef enum {
    FK_GOOD,
    FK_BAD_CRC,
    FK_ZERO_DATA,
    FK_ONE_NONZERO,
    FK_ABORTED,
    FK_NO_DEVICE
  } frame_kind_e;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  item_t       words_to_send[$];
  int unsigned quiet_cycles = 0;

  sensor_scratchpad_frame_checker_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  function automatic logic [7:0] crc8_lsb_first(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = {1'b0, c[7:1]} ^ CRC_POLY;
      end else begin
        c = {1'b0, c[7:1]};
      end
    end
    return c;
  endfunction

  class frame_scoreboard;
    logic [3:0]  byte_count;
    logic [7:0]  crc_acc;
    logic        seen_nonzero;
    logic [7:0]  low_byte;
    logic [7:0]  high_byte;
    result_t     awaited[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      clear_frame();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void clear_frame();
      byte_count   = '0;
      crc_acc      = '0;
      seen_nonzero = 1'b0;
      low_byte     = '0;
      high_byte    = '0;
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void absorb_word(input item_t w);
      result_t r;
      if (w.no_presence) begin
        r.status  = ST_NODEV;
        r.reading = SENTINEL_NODEV;
        awaited.push_back(r);
        clear_frame();
      end else if (byte_count < FRAME_DATA_BYTES) begin
        crc_acc = crc8_lsb_first(crc_acc, w.rx_byte);
        if (w.rx_byte != 8'h00) begin
          seen_nonzero = 1'b1;
        end
        if (byte_count == 4'd0) begin
          low_byte = w.rx_byte;
        end else if (byte_count == 4'd1) begin
          high_byte = w.rx_byte;
        end
        byte_count = byte_count + 4'd1;
      end else begin
        if (!seen_nonzero) begin
          r.status  = ST_ZERO;
          r.reading = SENTINEL_ZERO;
        end else if (crc_acc != w.rx_byte) begin
          r.status  = ST_CRC;
          r.reading = SENTINEL_CRC;
        end else begin
          r.status  = ST_OK;
          r.reading = {high_byte, low_byte};
        end
        awaited.push_back(r);
        clear_frame();
      end
    endfunction

    task check_result(input result_t got);
      result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result status %0d reading %0d",
                         got.status, $signed(got.reading)));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        report($sformatf("result %0d status %0d, want %0d",
                         results_seen, got.status, want.status));
      end
      if (got.reading !== want.reading) begin
        report($sformatf("result %0d reading %0d, want %0d",
                         results_seen, $signed(got.reading), $signed(want.reading)));
      end
    endtask
  endclass

  frame_scoreboard sb;

  function automatic void push_word(input logic np, input logic [7:0] b);
    item_t w;
    w.no_presence = np;
    w.rx_byte     = b;
    words_to_send.push_back(w);
  endfunction

  // push bytes 0..7 from data, low byte first, then the check byte xor crc_flip
  function automatic void push_data_frame(input logic [63:0] data, input logic [7:0] crc_flip);
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = crc8_lsb_first(c, data[i*8 +: 8]);
      push_word(1'b0, data[i*8 +: 8]);
    end
    push_word(1'b0, c ^ crc_flip);
  endfunction

  task drive_items;
    int unsigned idx;
    bit          taken;
    bit          steady;
    idx = 0;
    while (idx < words_to_send.size()) begin
      @(posedge clk);
      taken = item_valid && (item_stall === 1'b0);
      if (taken) begin
        sb.absorb_word(item);
        idx++;
      end
      if (!item_valid || taken) begin
        steady = (idx >= 900 && idx < 1300);
        if (idx >= words_to_send.size()) begin
          item_valid <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
          item_valid <= 1'b0;
          item       <= item_t'($urandom);
        end else begin
          item_valid <= 1'b1;
          item       <= words_to_send[idx];
        end
      end
    end
  endtask

  task pace_results;
    bit          held;
    int unsigned cyc;
    held = 1'b0;
    cyc  = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && sb.results_seen >= 40) begin
        // hold off long enough for both result slots to fill
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
        result_stall <= 1'b0;
      end else if (cyc >= 1200 && cyc < 1700) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_stall === 1'b0) ||
        (result_valid === 1'b1 && result_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sensor_scratchpad_frame_checker_unit: done, errors");
      $finish;
    end
  end

  initial begin
    frame_kind_e kind;
    int unsigned roll;
    int unsigned n;
    logic [63:0] data;

    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    sb           = new();

    // directed: no device at frame start, all-zero frame, extreme ok reading,
    // no device in the middle of a frame
    push_word(1'b1, 8'hFF);
    push_data_frame(64'h0, 8'h00);
    push_data_frame(64'hFFFF_FFFF_FFFF_8000, 8'h00);
    push_word(1'b0, 8'hFF);
    push_word(1'b0, 8'h7F);
    push_word(1'b0, 8'h12);
    push_word(1'b1, 8'h00);

    while (words_to_send.size() < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        kind = FK_GOOD;
      end else if (roll < 70) begin
        kind = FK_BAD_CRC;
      end else if (roll < 77) begin
        kind = FK_ZERO_DATA;
      end else if (roll < 85) begin
        kind = FK_ONE_NONZERO;
      end else if (roll < 95) begin
        kind = FK_ABORTED;
      end else begin
        kind = FK_NO_DEVICE;
      end
      data = {$urandom, $urandom};
      case (kind)
        FK_GOOD: begin
          case ($urandom_range(0, 9))
            0: data[15:0] = 16'h7FFF;
            1: data[15:0] = 16'h8000;
            2: data[15:0] = SENTINEL_CRC;
            3: data[15:0] = SENTINEL_NODEV;
            4: data[15:0] = SENTINEL_ZERO;
            5: data[15:0] = 16'h0000;
            default: ;
          endcase
          push_data_frame(data, 8'h00);
        end
        FK_BAD_CRC: begin
          push_data_frame(data, 8'($urandom_range(1, 255)));
        end
        FK_ZERO_DATA: begin
          push_data_frame(64'h0, 8'($urandom_range(0, 255)));
        end
        FK_ONE_NONZERO: begin
          data = 64'h0;
          data[$urandom_range(0, 7)*8 +: 8] = 8'($urandom_range(1, 255));
          push_data_frame(data, $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255)));
        end
        FK_ABORTED: begin
          n = $urandom_range(0, 8);
          for (int i = 0; i < n; i++) begin
            push_word(1'b0, 8'($urandom));
          end
          push_word(1'b1, 8'($urandom));
        end
        default: begin
          push_word(1'b1, 8'($urandom));
        end
      endcase
    end

    fork
      pace_results;
    join_none

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    drive_items;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("tb_sensor_scratchpad_frame_checker_unit: done, clean");
    end else begin
      $display("tb_sensor_scratchpad_frame_checker_unit: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/sfc_pkg.sv
rtl/sfc_frame.sv
rtl/sensor_scratchpad_frame_checker_unit.sv
verif/tb_sensor_scratchpad_frame_checker_unit.sv
